/* design/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* design/lfsa_pkg.sv */
// Shared types and constants of the lowest free slot allocator.
`default_nettype none
package lfsa_pkg;

  localparam int ID_W     = 10;
  localparam int TIME_W   = 30;
  localparam int CFG_W    = 9;
  localparam int OUTC_W   = 4;
  localparam int PLACE_W  = 9;
  localparam int CREDIT_W = 9;
  localparam int TOTAL_W  = 32;

  // Free-map search width per cycle.
  localparam int SCAN_W  = 16;
  localparam int SCAN_LG = 4;

  localparam logic [TOTAL_W-1:0] LIMIT_TOTAL = 32'd1000000100;
  localparam logic [CFG_W-1:0]   CFG_RESET   = 9'd256;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_ARRIVE = 2'd1;
  localparam logic [1:0] OP_LEAVE  = 2'd2;
  localparam logic [1:0] OP_REPORT = 2'd3;

  localparam logic [OUTC_W-1:0] OUT_CREDIT      = 4'd0;
  localparam logic [OUTC_W-1:0] OUT_PLACED      = 4'd1;
  localparam logic [OUTC_W-1:0] OUT_DROPPED     = 4'd2;
  localparam logic [OUTC_W-1:0] OUT_CREDIT_BACK = 4'd3;
  localparam logic [OUTC_W-1:0] OUT_FREED       = 4'd4;
  localparam logic [OUTC_W-1:0] OUT_IGNORED     = 4'd5;
  localparam logic [OUTC_W-1:0] OUT_FOUND       = 4'd6;
  localparam logic [OUTC_W-1:0] OUT_NONE        = 4'd7;
  localparam logic [OUTC_W-1:0] OUT_STARTED     = 4'd8;

  // Controller to datapath.
  typedef struct packed {
    logic              load_in;
    logic              clr_start;
    logic              clr_step;
    logic              start_load;
    logic              take_credit;
    logic              give_credit;
    logic              hold_rd;
    logic              hold_wr_credit;
    logic              hold_wr_place;
    logic              hold_wr_clear;
    logic              fscan_start;
    logic              fscan_step;
    logic              claim_place;
    logic              use_rd;
    logic              use_wr;
    logic              rscan_start;
    logic              rscan_step;
    logic              rscan_cmp;
    logic              emit;
    logic [OUTC_W-1:0] outcome;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_last;
    logic id_ok;
    logic credits_nz;
    logic fscan_hit;
    logic fscan_last;
    logic hold_credit;
    logic hold_place_ok;
    logic m_zero;
    logic rscan_last;
    logic found_any;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* design/lfsa_if.sv */
// Valid/ready channel interfaces for items and results.
`default_nettype none
interface lfsa_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 operation;
  logic [lfsa_pkg::ID_W-1:0]   request_id;
  logic [lfsa_pkg::TIME_W-1:0] event_time;

  modport source (output valid, output operation, output request_id, output event_time,
                  input ready);
  modport sink   (input valid, input operation, input request_id, input event_time,
                  output ready);
endinterface

interface lfsa_out_if;
  logic                        valid;
  logic                        ready;
  logic [lfsa_pkg::OUTC_W-1:0]  outcome;
  logic [lfsa_pkg::PLACE_W-1:0] place;
  logic [lfsa_pkg::TIME_W-1:0]  min_total;

  modport source (output valid, output outcome, output place, output min_total,
                  input ready);
  modport sink   (input valid, input outcome, input place, input min_total,
                  output ready);
endinterface
`default_nettype wire

/* design/lowest_free_slot_allocator_with_usage_top.sv */
// Top level of the lowest free slot allocator with usage accounting.
`default_nettype none
`include "assert_macros.svh"
// Hands out places 1..place_count to timed requests, credits first, then the
// lowest free place, and keeps a saturating usage total per place; a report
// returns the least-used place (lowest index on ties) among totals below the
// limit. One item is worked on at a time; the result register lets the next
// item in while a result waits. An arrive without a credit steps through the
// free map 16 places at a time; a leave reads the holder and, for a placed
// request, does a read-modify-write of the usage total; a report reads the
// usage memory once per place, unless place_count is zero; a start clears one
// holder and usage entry per cycle. After reset the same clearing pass runs
// over max(REQUESTS, PLACES) entries before the first item is taken;
// configuration writes are taken at any time.
module lowest_free_slot_allocator_with_usage_top #(
  parameter int PLACES   = 256,
  parameter int REQUESTS = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [lfsa_pkg::CFG_W-1:0] cfg_wr_data,
  lfsa_in_if.sink                        in_chan,
  lfsa_out_if.source                     out_chan
);

  lfsa_pkg::cmd_t cmd;
  lfsa_pkg::sts_t sts;
  logic           in_ready;

  assign in_chan.ready = in_ready;

  lfsa_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_operation (in_chan.operation),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  lfsa_datapath #(
    .PLACES   (PLACES),
    .REQUESTS (REQUESTS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_request_id (in_chan.request_id),
    .in_event_time (in_chan.event_time),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_chan.ready),
    .out_valid     (out_chan.valid),
    .out_outcome   (out_chan.outcome),
    .out_place     (out_chan.place),
    .out_min_total (out_chan.min_total)
  );

  // one item in flight: no transfer right after a transfer
  `ASSERT_NEXT(a_one_item, clk, rst_n, in_chan.valid && in_ready, !in_ready)
  // never overwrite a waiting result
  `ASSERT_NOW(a_emit_free, clk, rst_n, cmd.emit, !out_chan.valid || out_chan.ready)
  // a credit is only taken while one is left
  `ASSERT_NOW(a_credit_take, clk, rst_n, cmd.take_credit, sts.credits_nz)
  // no item is taken during the clearing pass
  `ASSERT_NOW(a_clear_busy, clk, rst_n, cmd.clr_step, !in_ready)

endmodule
`default_nettype wire

/* design/lfsa_ctrl.sv */
// Sequencing state machine of the allocator.
`default_nettype none
module lfsa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic [1:0]     in_operation,
  output logic                in_ready,
  input  wire lfsa_pkg::sts_t sts,
  output lfsa_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_CLR_RST, ST_CLR_START, ST_ARRIVE, ST_FSCAN, ST_PLACE,
    ST_LEAVE, ST_LCHK, ST_LADD, ST_REPORT, ST_RSCAN, ST_RTAIL, ST_RFIN, ST_EMIT
  } state_t;

  state_t                        state_r, state_nxt;
  logic [lfsa_pkg::OUTC_W-1:0]   outc_r, outc_nxt;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    outc_nxt    = outc_r;
    in_ready    = (state_r == ST_IDLE);
    cmd.outcome = outc_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          case (in_operation)
            lfsa_pkg::OP_START:  state_nxt = ST_START;
            lfsa_pkg::OP_ARRIVE: state_nxt = ST_ARRIVE;
            lfsa_pkg::OP_LEAVE:  state_nxt = ST_LEAVE;
            default:             state_nxt = ST_REPORT;
          endcase
        end
      end
      ST_START: begin
        cmd.start_load = 1'b1;
        cmd.clr_start  = 1'b1;
        state_nxt      = ST_CLR_START;
      end
      ST_CLR_RST, ST_CLR_START: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          if (state_r == ST_CLR_RST) begin
            state_nxt = ST_IDLE;
          end else begin
            outc_nxt  = lfsa_pkg::OUT_STARTED;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_ARRIVE: begin
        if (!sts.id_ok) begin
          outc_nxt  = lfsa_pkg::OUT_DROPPED;
          state_nxt = ST_EMIT;
        end else if (sts.credits_nz) begin
          cmd.take_credit    = 1'b1;
          cmd.hold_wr_credit = 1'b1;
          outc_nxt           = lfsa_pkg::OUT_CREDIT;
          state_nxt          = ST_EMIT;
        end else begin
          cmd.fscan_start = 1'b1;
          state_nxt       = ST_FSCAN;
        end
      end
      ST_FSCAN: begin
        cmd.fscan_step = 1'b1;
        if (sts.fscan_hit) begin
          state_nxt = ST_PLACE;
        end else if (sts.fscan_last) begin
          // no free place: drop and clear the holding
          cmd.hold_wr_clear = 1'b1;
          outc_nxt          = lfsa_pkg::OUT_DROPPED;
          state_nxt         = ST_EMIT;
        end
      end
      ST_PLACE: begin
        cmd.claim_place   = 1'b1;
        cmd.hold_wr_place = 1'b1;
        outc_nxt          = lfsa_pkg::OUT_PLACED;
        state_nxt         = ST_EMIT;
      end
      ST_LEAVE: begin
        if (!sts.id_ok) begin
          outc_nxt  = lfsa_pkg::OUT_IGNORED;
          state_nxt = ST_EMIT;
        end else begin
          cmd.hold_rd = 1'b1;
          state_nxt   = ST_LCHK;
        end
      end
      ST_LCHK: begin
        if (sts.hold_credit) begin
          cmd.give_credit   = 1'b1;
          cmd.hold_wr_clear = 1'b1;
          outc_nxt          = lfsa_pkg::OUT_CREDIT_BACK;
          state_nxt         = ST_EMIT;
        end else if (sts.hold_place_ok) begin
          cmd.use_rd = 1'b1;
          state_nxt  = ST_LADD;
        end else begin
          cmd.hold_wr_clear = 1'b1;
          outc_nxt          = lfsa_pkg::OUT_IGNORED;
          state_nxt         = ST_EMIT;
        end
      end
      ST_LADD: begin
        cmd.use_wr        = 1'b1;
        cmd.hold_wr_clear = 1'b1;
        outc_nxt          = lfsa_pkg::OUT_FREED;
        state_nxt         = ST_EMIT;
      end
      ST_REPORT: begin
        if (sts.m_zero) begin
          outc_nxt  = lfsa_pkg::OUT_NONE;
          state_nxt = ST_EMIT;
        end else begin
          cmd.rscan_start = 1'b1;
          state_nxt       = ST_RSCAN;
        end
      end
      ST_RSCAN: begin
        cmd.rscan_step = 1'b1;
        if (sts.rscan_last) begin
          state_nxt = ST_RTAIL;
        end
      end
      ST_RTAIL: begin
        // compare the last read
        cmd.rscan_cmp = 1'b1;
        state_nxt     = ST_RFIN;
      end
      ST_RFIN: begin
        outc_nxt  = sts.found_any ? lfsa_pkg::OUT_FOUND : lfsa_pkg::OUT_NONE;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR_RST;
      outc_r  <= lfsa_pkg::OUT_STARTED;
    end else begin
      state_r <= state_nxt;
      outc_r  <= outc_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/lfsa_datapath.sv */
// Datapath: holder and usage memories, free map, credits, scans and result register.
`default_nettype none
module lfsa_datapath #(
  parameter int PLACES   = 256,
  parameter int REQUESTS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [lfsa_pkg::CFG_W-1:0]     cfg_wr_data,
  input  wire logic [lfsa_pkg::ID_W-1:0]      in_request_id,
  input  wire logic [lfsa_pkg::TIME_W-1:0]    in_event_time,
  input  wire lfsa_pkg::cmd_t                cmd,
  output lfsa_pkg::sts_t                     sts,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [lfsa_pkg::OUTC_W-1:0]         out_outcome,
  output logic [lfsa_pkg::PLACE_W-1:0]        out_place,
  output logic [lfsa_pkg::TIME_W-1:0]         out_min_total
);

  localparam int PW    = $clog2(PLACES + 1);
  localparam int PIW   = $clog2(PLACES);
  localparam int RW    = $clog2(REQUESTS);
  localparam int CLR_N = (REQUESTS > PLACES) ? REQUESTS : PLACES;
  localparam int CLW   = $clog2(CLR_N);
  localparam int NCH   = (PLACES + lfsa_pkg::SCAN_W - 1) / lfsa_pkg::SCAN_W;
  localparam int CHW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int TW    = lfsa_pkg::TIME_W;
  localparam int HW    = 1 + PW + TW;
  localparam int TOTW  = lfsa_pkg::TOTAL_W;

  // configuration and captured item
  logic [lfsa_pkg::CFG_W-1:0]   cfg_count_r;
  logic [lfsa_pkg::ID_W-1:0]    id_r;
  logic [TW-1:0]               t_r;
  logic [PW-1:0]               m_w;
  logic [RW-1:0]               hidx;

  logic [lfsa_pkg::CREDIT_W-1:0] credits_r;
  logic [PLACES-1:0]             free_r;
  logic [CLW-1:0]                clr_cnt_r;

  // holder memory: {credit, place, start time}
  logic [HW-1:0]  hold_mem [REQUESTS];
  logic [HW-1:0]  hold_q_r;
  logic [PW-1:0]  hold_place;
  logic [TW-1:0]  hold_time;

  // usage memory, indexed by place - 1
  logic [TOTW-1:0] use_mem [PLACES];
  logic [TOTW-1:0] use_q_r;
  logic [TW-1:0]   el_r;
  logic [TOTW:0]   sum_w;
  logic [TOTW-1:0] sat_w;

  // free-place search
  logic [NCH*lfsa_pkg::SCAN_W-1:0] free_pad;
  logic [lfsa_pkg::SCAN_W-1:0]     chunk;
  logic [CHW-1:0]                  fch_r;
  logic                            hit;
  logic [lfsa_pkg::SCAN_LG-1:0]    hit_j;
  logic [PW-1:0]                   fnd_comb;
  logic [PW-1:0]                   fnd_r;

  // least-used search
  logic [PIW-1:0]  rcnt_r;
  logic            rpend_r;
  logic [PW-1:0]   rplace_r;
  logic [TOTW-1:0] best_r;
  logic [PW-1:0]   where_r;

  logic [PW-1:0]                sel_place;
  logic [TW-1:0]                sel_total;

  assign m_w = (32'(cfg_count_r) > PLACES) ? PW'(PLACES) : PW'(cfg_count_r);
  assign hidx = RW'(id_r);
  assign hold_place = hold_q_r[HW-2 -: PW];
  assign hold_time  = hold_q_r[TW-1:0];

  for (genvar k = 0; k < NCH * lfsa_pkg::SCAN_W; k++) begin : g_pad
    if (k < PLACES) begin : g_live
      assign free_pad[k] = free_r[k] && (32'(k) < 32'(m_w));
    end else begin : g_dead
      assign free_pad[k] = 1'b0;
    end
  end

  assign chunk = free_pad[(32'(fch_r) << lfsa_pkg::SCAN_LG) +: lfsa_pkg::SCAN_W];

  always_comb begin
    hit   = 1'b0;
    hit_j = '0;
    for (int j = lfsa_pkg::SCAN_W - 1; j >= 0; j--) begin
      if (chunk[j]) begin
        hit   = 1'b1;
        hit_j = lfsa_pkg::SCAN_LG'(j);
      end
    end
  end

  assign fnd_comb = PW'((32'(fch_r) << lfsa_pkg::SCAN_LG) + 32'(hit_j) + 32'd1);

  assign sum_w = {1'b0, use_q_r} + (TOTW + 1)'(el_r);
  assign sat_w = sum_w[TOTW] ? '1 : sum_w[TOTW-1:0];

  always_comb begin
    sts.clr_last      = (clr_cnt_r == CLW'(CLR_N - 1));
    sts.id_ok         = (32'(id_r) < REQUESTS);
    sts.credits_nz    = (credits_r != '0);
    sts.fscan_hit     = hit;
    sts.fscan_last    = (fch_r == CHW'(NCH - 1));
    sts.hold_credit   = hold_q_r[HW-1];
    sts.hold_place_ok = (hold_place != '0) && (32'(hold_place) <= PLACES);
    sts.m_zero        = (m_w == '0);
    sts.rscan_last    = (rcnt_r == PIW'(m_w - 1'b1));
    sts.found_any     = (where_r != '0);
    sts.out_free      = !out_valid || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= lfsa_pkg::CFG_RESET;
      credits_r   <= '0;
      free_r      <= '1;
      clr_cnt_r   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_count_r <= cfg_wr_data;
      end
      if (cmd.start_load) begin
        credits_r <= (m_w == '0) ? '0 : lfsa_pkg::CREDIT_W'(m_w - 1'b1);
        for (int k = 0; k < PLACES; k++) begin
          free_r[k] <= (32'(k) < 32'(m_w));
        end
      end
      if (cmd.take_credit) begin
        credits_r <= credits_r - 1'b1;
      end
      if (cmd.give_credit && (credits_r != '1)) begin
        credits_r <= credits_r + 1'b1;
      end
      if (cmd.claim_place) begin
        free_r[PIW'(fnd_r - 1'b1)] <= 1'b0;
      end
      if (cmd.use_wr) begin
        free_r[PIW'(hold_place - 1'b1)] <= 1'b1;
      end
      if (cmd.clr_start) begin
        clr_cnt_r <= '0;
      end else if (cmd.clr_step && !sts.clr_last) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // holder memory
  always_ff @(posedge clk) begin
    if (cmd.clr_step && (32'(clr_cnt_r) < REQUESTS)) begin
      hold_mem[RW'(clr_cnt_r)] <= '0;
    end else if (cmd.hold_wr_credit) begin
      hold_mem[hidx] <= {1'b1, PW'(0), TW'(0)};
    end else if (cmd.hold_wr_place) begin
      hold_mem[hidx] <= {1'b0, fnd_r, t_r};
    end else if (cmd.hold_wr_clear) begin
      hold_mem[hidx] <= '0;
    end
    if (cmd.hold_rd) begin
      hold_q_r <= hold_mem[hidx];
    end
  end

  // usage memory
  always_ff @(posedge clk) begin
    if (cmd.clr_step && (32'(clr_cnt_r) < PLACES)) begin
      use_mem[PIW'(clr_cnt_r)] <= '0;
    end else if (cmd.use_wr) begin
      use_mem[PIW'(hold_place - 1'b1)] <= sat_w;
    end
    if (cmd.use_rd) begin
      use_q_r <= use_mem[PIW'(hold_place - 1'b1)];
    end else if (cmd.rscan_step) begin
      use_q_r <= use_mem[rcnt_r];
    end
  end

  // captured item, scan registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      id_r <= in_request_id;
      t_r  <= in_event_time;
    end
    if (cmd.use_rd) begin
      // leave before arrival counts as zero
      el_r <= (t_r >= hold_time) ? (t_r - hold_time) : '0;
    end
    if (cmd.fscan_start) begin
      fch_r <= '0;
    end else if (cmd.fscan_step) begin
      if (hit) begin
        fnd_r <= fnd_comb;
      end
      fch_r <= fch_r + 1'b1;
    end
    if (cmd.rscan_start) begin
      rcnt_r  <= '0;
      rpend_r <= 1'b0;
      best_r  <= lfsa_pkg::LIMIT_TOTAL;
      where_r <= '0;
    end else if (cmd.rscan_step || cmd.rscan_cmp) begin
      if (rpend_r && (use_q_r < best_r)) begin
        best_r  <= use_q_r;
        where_r <= rplace_r;
      end
      rpend_r  <= cmd.rscan_step;
      rplace_r <= PW'(rcnt_r) + 1'b1;
      rcnt_r   <= rcnt_r + 1'b1;
    end
  end

  // result fields by outcome
  always_comb begin
    sel_place = '0;
    sel_total = '0;
    case (cmd.outcome)
      lfsa_pkg::OUT_PLACED: sel_place = fnd_r;
      lfsa_pkg::OUT_FREED:  sel_place = hold_place;
      lfsa_pkg::OUT_FOUND: begin
        sel_place = where_r;
        sel_total = best_r[TW-1:0];
      end
      lfsa_pkg::OUT_NONE:   sel_total = lfsa_pkg::LIMIT_TOTAL[TW-1:0];
      default: begin
        sel_place = '0;
        sel_total = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_outcome   <= cmd.outcome;
      out_place     <= lfsa_pkg::PLACE_W'(sel_place);
      out_min_total <= sel_total;
    end
  end

endmodule
`default_nettype wire
